/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the requantiser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds on every clock edge outside reset
`define PCRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define PCRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle
`define PCRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PCRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/pcrq_pkg.sv */
// ----------------------------------------------------------------------------
// pcrq_pkg
// Types and constants shared by the per-channel int8 requantiser.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrq_pkg;

  // Queue depths between the stages
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;

  // Configuration register map (index = paddr[4:2])
  typedef enum logic [2:0] {
    REG_ACT_MIN       = 3'd0,
    REG_ACT_MAX       = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_PLANE_SIZE    = 3'd3,
    REG_BATCH_COUNT   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [7:0] act_min;
    logic signed [7:0] act_max;
    logic [6:0]        channel_count;
    logic [16:0]       plane_size;
    logic [15:0]       batch_count;
  } cfg_t;

  // One entry of the channel parameter table
  typedef struct packed {
    logic signed [31:0] mult;
    logic signed [31:0] bias;
    logic [4:0]         shift;
  } tab_t;

  // Work carried from the front end to the back end
  typedef struct packed {
    logic              is_load;
    tab_t              tab;
    logic signed [7:0] sample;
    logic              last_plane;
    logic              last_batch;
  } work_t;

  typedef struct packed {
    logic signed [7:0] result;
    logic              last_plane;
    logic              last_batch;
  } res_t;

endpackage

`default_nettype wire

/* design/pcrq_ram.sv */
// ----------------------------------------------------------------------------
// pcrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/pcrq_fifo.sv */
// ----------------------------------------------------------------------------
// pcrq_fifo
// Small flop-based FIFO with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcrq_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `PCRQ_ASSERT_IMP(fifo_no_overflow_a, clk_i, rst_ni, push_i, !full_o, "push into full fifo")
  `PCRQ_ASSERT(fifo_count_range_a, clk_i, rst_ni, count_q <= CntW'(Depth), "fifo count overrun")

endmodule

`default_nettype wire

/* design/pcrq_front.sv */
// ----------------------------------------------------------------------------
// pcrq_front
// Accepts requests, walks the NCHW position counters and queues the work.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcrq_front #(
  parameter int unsigned MaxChannels = 64,
  localparam int unsigned ChAw = (MaxChannels > 1) ? $clog2(MaxChannels) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcrq_pkg::cfg_t      cfg_i,
  input  logic                push_i,
  input  logic                func_i,
  input  logic [5:0]          channel_index_i,
  input  logic signed [31:0]  multiplier_i,
  input  logic signed [31:0]  bias_i,
  input  logic [4:0]          shift_i,
  input  logic signed [7:0]   sample_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output pcrq_pkg::work_t     q_work_o,
  output logic [ChAw-1:0]     q_addr_o
);

  logic [15:0] plane_pos_q, plane_pos_d;
  logic [5:0]  cur_ch_q, cur_ch_d;
  logic [15:0] cur_img_q, cur_img_d;

  logic [15:0] plane_last, imgs_last;
  logic [6:0]  chans_last, ch_sel;
  logic        is_sample, accept, sample_acc, load_ok;
  logic        lp, lc, li;
  logic [ChAw+6:0] ch_ext;
  logic [ChAw+5:0] idx_ext;

  assign is_sample  = (pcrq_pkg::func_e'(func_i) == pcrq_pkg::FUNC_SAMPLE);
  assign accept     = push_i & ~q_full_i;
  assign sample_acc = accept & is_sample;
  assign load_ok    = ({26'd0, channel_index_i} < 32'(MaxChannels));

  // Effective last positions: zero acts as one, oversize clamps
  always_comb begin
    if (cfg_i.plane_size == '0) begin
      plane_last = '0;
    end else if (cfg_i.plane_size[16]) begin
      plane_last = 16'hFFFF;
    end else begin
      plane_last = cfg_i.plane_size[15:0] - 16'd1;
    end
    if (cfg_i.channel_count == '0) begin
      chans_last = '0;
    end else if ({25'd0, cfg_i.channel_count} > 32'(MaxChannels)) begin
      chans_last = 7'(MaxChannels - 1);
    end else begin
      chans_last = cfg_i.channel_count - 7'd1;
    end
    imgs_last = (cfg_i.batch_count == '0) ? '0 : cfg_i.batch_count - 16'd1;
  end

  assign lp = (plane_pos_q >= plane_last);
  assign lc = ({1'b0, cur_ch_q} >= chans_last);
  assign li = (cur_img_q >= imgs_last);

  // Channel past the bound reads the last channel
  assign ch_sel  = lc ? chans_last : {1'b0, cur_ch_q};
  assign ch_ext  = {{ChAw{1'b0}}, ch_sel};
  assign idx_ext = {{ChAw{1'b0}}, channel_index_i};

  always_comb begin
    q_push_o            = accept & (is_sample | load_ok);
    q_work_o.is_load    = ~is_sample;
    q_work_o.tab.mult   = multiplier_i;
    q_work_o.tab.bias   = bias_i;
    q_work_o.tab.shift  = shift_i;
    q_work_o.sample     = sample_i;
    q_work_o.last_plane = lp;
    q_work_o.last_batch = lp & lc & li;
    q_addr_o            = is_sample ? ch_ext[ChAw-1:0] : idx_ext[ChAw-1:0];
  end

  always_comb begin
    plane_pos_d = plane_pos_q;
    cur_ch_d    = cur_ch_q;
    cur_img_d   = cur_img_q;
    if (sample_acc) begin
      if (!lp) begin
        plane_pos_d = plane_pos_q + 16'd1;
      end else begin
        plane_pos_d = '0;
        if (!lc) begin
          cur_ch_d = cur_ch_q + 6'd1;
        end else begin
          cur_ch_d  = '0;
          cur_img_d = li ? '0 : cur_img_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_pos_q <= '0;
      cur_ch_q    <= '0;
      cur_img_q   <= '0;
    end else begin
      plane_pos_q <= plane_pos_d;
      cur_ch_q    <= cur_ch_d;
      cur_img_q   <= cur_img_d;
    end
  end

  `PCRQ_ASSERT_NEXT(front_plane_wrap_a, clk_i, rst_ni, sample_acc && lp, plane_pos_q == '0, "plane position did not wrap")

endmodule

`default_nettype wire

/* design/pcrq_back.sv */
// ----------------------------------------------------------------------------
// pcrq_back
// Table write/read, multiply-add, rounding shift and clamp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcrq_back #(
  parameter int unsigned MaxChannels = 64,
  localparam int unsigned ChAw = (MaxChannels > 1) ? $clog2(MaxChannels) : 1,
  localparam int unsigned OutCntW = $clog2(pcrq_pkg::OUT_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [7:0]    act_min_i,
  input  logic signed [7:0]    act_max_i,
  input  logic                 q_empty_i,
  input  pcrq_pkg::work_t      q_work_i,
  input  logic [ChAw-1:0]      q_addr_i,
  output logic                 q_pop_o,
  input  logic [OutCntW-1:0]   out_count_i,
  output logic                 res_push_o,
  output pcrq_pkg::res_t       res_o
);

  localparam int unsigned TabW = $bits(pcrq_pkg::tab_t);

  // Stage valids, one per pipeline register
  logic v1_q, v2_q, v3_q, v4_q;
  logic [3:0] inflight;
  logic [OutCntW:0] committed;
  logic credit_ok, rd_en, wr_en;

  // Stage 1: waiting on table read
  logic signed [7:0] s1_sample_q;
  logic s1_lp_q, s1_lb_q;
  pcrq_pkg::tab_t tab_rd;
  logic [TabW-1:0] tab_rd_raw;
  logic signed [39:0] prod_wide;

  // Stage 2: product
  logic [31:0] s2_prod_q, s2_bias_q;
  logic [4:0]  s2_shift_q;
  logic        s2_lp_q, s2_lb_q;

  // Stage 3: accumulator
  logic [31:0] s3_acc_q;
  logic [4:0]  s3_shift_q;
  logic        s3_lp_q, s3_lb_q;
  logic        s3_neg;
  logic [31:0] s3_mag, s3_rnd;
  logic [32:0] s3_sum;

  // Stage 4: rounded magnitude
  logic [32:0] s4_sum_q;
  logic [4:0]  s4_shift_q;
  logic        s4_neg_q, s4_lp_q, s4_lb_q;
  logic [32:0] s4_q;
  logic [8:0]  s4_sat;
  logic signed [9:0] s4_mag, s4_r, s4_lo, s4_hi, s4_r1, s4_r2;

  // Issue a sample only when the result queue has room for everything in flight
  assign inflight  = {v1_q, v2_q, v3_q, v4_q};
  assign committed = {1'b0, out_count_i} + (OutCntW + 1)'($countones(inflight));
  assign credit_ok = (committed < (OutCntW + 1)'(pcrq_pkg::OUT_DEPTH));
  assign q_pop_o   = ~q_empty_i & (q_work_i.is_load | credit_ok);
  assign wr_en     = q_pop_o & q_work_i.is_load;
  assign rd_en     = q_pop_o & ~q_work_i.is_load;

  pcrq_ram #(
    .Width (TabW),
    .Depth (MaxChannels)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (q_addr_i),
    .wdata_i (q_work_i.tab),
    .re_i    (rd_en),
    .raddr_i (q_addr_i),
    .rdata_o (tab_rd_raw)
  );

  assign tab_rd    = pcrq_pkg::tab_t'(tab_rd_raw);
  assign prod_wide = s1_sample_q * tab_rd.mult;

  // Magnitude plus rounding offset; negative values negate through ~acc + 1
  always_comb begin
    s3_neg = s3_acc_q[31];
    s3_mag = s3_neg ? ~s3_acc_q : s3_acc_q;
    s3_rnd = (s3_shift_q == '0) ? '0 : (32'd1 << (s3_shift_q - 5'd1));
    s3_sum = {1'b0, s3_mag} + {1'b0, s3_rnd} + {32'd0, s3_neg};
  end

  // Shift, saturate the magnitude to nine bits, restore sign, clamp low then high
  always_comb begin
    s4_q   = s4_sum_q >> s4_shift_q;
    s4_sat = (|s4_q[32:9]) ? 9'h1FF : s4_q[8:0];
    s4_mag = {1'b0, s4_sat};
    s4_r   = s4_neg_q ? -s4_mag : s4_mag;
    s4_lo  = {{2{act_min_i[7]}}, act_min_i};
    s4_hi  = {{2{act_max_i[7]}}, act_max_i};
    s4_r1  = (s4_r < s4_lo) ? s4_lo : s4_r;
    s4_r2  = (s4_r1 > s4_hi) ? s4_hi : s4_r1;
    res_push_o       = v4_q;
    res_o.result     = s4_r2[7:0];
    res_o.last_plane = s4_lp_q;
    res_o.last_batch = s4_lb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sample_q <= q_work_i.sample;
    s1_lp_q     <= q_work_i.last_plane;
    s1_lb_q     <= q_work_i.last_batch;

    s2_prod_q   <= prod_wide[31:0];
    s2_bias_q   <= tab_rd.bias;
    s2_shift_q  <= tab_rd.shift;
    s2_lp_q     <= s1_lp_q;
    s2_lb_q     <= s1_lb_q;

    s3_acc_q    <= s2_prod_q + s2_bias_q;
    s3_shift_q  <= s2_shift_q;
    s3_lp_q     <= s2_lp_q;
    s3_lb_q     <= s2_lb_q;

    s4_sum_q    <= s3_sum;
    s4_shift_q  <= s3_shift_q;
    s4_neg_q    <= s3_neg;
    s4_lp_q     <= s3_lp_q;
    s4_lb_q     <= s3_lb_q;
  end

  `PCRQ_ASSERT(back_credit_a, clk_i, rst_ni, committed <= (OutCntW + 1)'(pcrq_pkg::OUT_DEPTH), "result queue overcommitted")
  `PCRQ_ASSERT_IMP(back_room_a, clk_i, rst_ni, v4_q, out_count_i < OutCntW'(pcrq_pkg::OUT_DEPTH), "no room for result")

endmodule

`default_nettype wire

/* design/per_channel_int8_requantize_top.sv */
// ----------------------------------------------------------------------------
// per_channel_int8_requantize_top
// Per-channel int8 batch-norm requantiser with APB configuration.
// ----------------------------------------------------------------------------
// One request is taken per clock unless the work queue is full. Load requests
// (func 0) write a channel's multiplier, bias and shift into the parameter
// table; sample requests (func 1) follow NCHW order, take their channel from
// internal position counters and give one int8 result with end-of-plane and
// end-of-batch flags. A request enters a four-deep work queue in the cycle it
// is accepted; the back end takes one entry per cycle unless a sample waits
// for result queue room, reads the table RAM and runs a multiply, add, round
// and clamp pipeline. Throughput is one request per cycle while neither queue
// stalls, set by the single table read port and the one multiplier stage;
// samples are issued only while the eight-deep result queue has room for all
// results in flight, so a stalled consumer holds the back end. Table entries
// must be loaded before a sample uses them. Configuration writes are meant
// for idle periods; they do not move the position counters.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_int8_requantize_top #(
  parameter int unsigned MaxChannels = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Request side
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [5:0]         channel_index_i,
  input  logic signed [31:0] multiplier_i,
  input  logic signed [31:0] bias_i,
  input  logic [4:0]         shift_i,
  input  logic signed [7:0]  sample_i,
  // Result side
  output logic               empty,
  input  logic               pop,
  output logic signed [7:0]  result_o,
  output logic               last_of_plane_o,
  output logic               last_of_batch_o
);

  localparam int unsigned ChAw    = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned WorkW   = $bits(pcrq_pkg::work_t) + ChAw;
  localparam int unsigned ResW    = $bits(pcrq_pkg::res_t);
  localparam int unsigned OutCntW = $clog2(pcrq_pkg::OUT_DEPTH + 1);

  logic signed [7:0] act_min_q, act_max_q;
  logic [6:0]        channel_count_q;
  logic [16:0]       plane_size_q;
  logic [15:0]       batch_count_q;
  pcrq_pkg::cfg_t    cfg;
  logic              cfg_wr;
  pcrq_pkg::reg_idx_e reg_idx;

  logic              mid_push, mid_full, mid_empty, mid_pop;
  pcrq_pkg::work_t   front_work, back_work;
  logic [ChAw-1:0]   front_addr, back_addr;
  logic [WorkW-1:0]  mid_rd;

  logic              res_push;
  pcrq_pkg::res_t    res_in, res_out;
  logic [ResW-1:0]   res_rd;
  logic [OutCntW-1:0] out_count;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = pcrq_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_min_q       <= -8'sd128;
      act_max_q       <= 8'sd127;
      channel_count_q <= 7'd1;
      plane_size_q    <= 17'd1;
      batch_count_q   <= 16'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        pcrq_pkg::REG_ACT_MIN:       act_min_q       <= pwdata[7:0];
        pcrq_pkg::REG_ACT_MAX:       act_max_q       <= pwdata[7:0];
        pcrq_pkg::REG_CHANNEL_COUNT: channel_count_q <= pwdata[6:0];
        pcrq_pkg::REG_PLANE_SIZE:    plane_size_q    <= pwdata[16:0];
        pcrq_pkg::REG_BATCH_COUNT:   batch_count_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pcrq_pkg::REG_ACT_MIN:       prdata = {24'd0, act_min_q};
      pcrq_pkg::REG_ACT_MAX:       prdata = {24'd0, act_max_q};
      pcrq_pkg::REG_CHANNEL_COUNT: prdata = {25'd0, channel_count_q};
      pcrq_pkg::REG_PLANE_SIZE:    prdata = {15'd0, plane_size_q};
      pcrq_pkg::REG_BATCH_COUNT:   prdata = {16'd0, batch_count_q};
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.act_min       = act_min_q;
    cfg.act_max       = act_max_q;
    cfg.channel_count = channel_count_q;
    cfg.plane_size    = plane_size_q;
    cfg.batch_count   = batch_count_q;
  end

  pcrq_front #(
    .MaxChannels (MaxChannels)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .push_i          (push),
    .func_i          (func_i),
    .channel_index_i (channel_index_i),
    .multiplier_i    (multiplier_i),
    .bias_i          (bias_i),
    .shift_i         (shift_i),
    .sample_i        (sample_i),
    .q_full_i        (mid_full),
    .q_push_o        (mid_push),
    .q_work_o        (front_work),
    .q_addr_o        (front_addr)
  );

  assign full = mid_full;

  pcrq_fifo #(
    .Width (WorkW),
    .Depth (pcrq_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  ({front_work, front_addr}),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rd),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign back_work = pcrq_pkg::work_t'(mid_rd[WorkW-1:ChAw]);
  assign back_addr = mid_rd[ChAw-1:0];

  pcrq_back #(
    .MaxChannels (MaxChannels)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_min_i   (act_min_q),
    .act_max_i   (act_max_q),
    .q_empty_i   (mid_empty),
    .q_work_i    (back_work),
    .q_addr_i    (back_addr),
    .q_pop_o     (mid_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pcrq_fifo #(
    .Width (ResW),
    .Depth (pcrq_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (res_rd),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign res_out         = pcrq_pkg::res_t'(res_rd);
  assign result_o        = res_out.result;
  assign last_of_plane_o = res_out.last_plane;
  assign last_of_batch_o = res_out.last_batch;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the per-channel int8 requantiser against its own bit-exact predictor.
// Runs a directed table of extremes and rounding cases, then random sample
// streams over many size and clamp settings. Both queue sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam int DRAIN       = 16;    // margin for the load tail to drain

  typedef struct packed {
    pcrq_pkg::func_e    func;
    logic [5:0]         chan;
    logic signed [31:0] mult;
    logic signed [31:0] bias;
    logic [4:0]         shift;
    logic signed [7:0]  x;
  } act_req_t;

  typedef struct packed {
    logic signed [7:0] act;
    logic              eop;
    logic              eob;
  } act_out_t;

  typedef struct packed {
    act_req_t req;
    logic     typed;
    act_out_t want;
  } dir_row_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [4:0]         paddr           = '0;
  logic [31:0]        pwdata          = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               push            = 1'b0;
  logic               full;
  logic               func_i          = 1'b0;
  logic [5:0]         channel_index_i = '0;
  logic signed [31:0] multiplier_i    = '0;
  logic signed [31:0] bias_i          = '0;
  logic [4:0]         shift_i         = '0;
  logic signed [7:0]  sample_i        = '0;
  logic               empty;
  logic               pop             = 1'b0;
  logic signed [7:0]  result_o;
  logic               last_of_plane_o;
  logic               last_of_batch_o;

  per_channel_int8_requantize_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .func_i          (func_i),
    .channel_index_i (channel_index_i),
    .multiplier_i    (multiplier_i),
    .bias_i          (bias_i),
    .shift_i         (shift_i),
    .sample_i        (sample_i),
    .empty           (empty),
    .pop             (pop),
    .result_o        (result_o),
    .last_of_plane_o (last_of_plane_o),
    .last_of_batch_o (last_of_batch_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: channel tables, position counters and register copies
  logic [31:0]       mult_tab  [64];
  logic [31:0]       bias_tab  [64];
  logic [4:0]        shift_tab [64];
  logic [15:0]       pos_in_plane = '0;
  logic [5:0]        chan_now     = '0;
  logic [15:0]       image_now    = '0;
  logic signed [7:0] clamp_lo     = -8'sd128;
  logic signed [7:0] clamp_hi     = 8'sd127;
  logic [6:0]        chans_reg    = 7'd1;
  logic [16:0]       plane_reg    = 17'd1;
  logic [15:0]       batch_reg    = 16'd1;

  act_out_t pending_acts[$];
  bit       steady = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       n_loads = 0, n_samples = 0, n_checked = 0;
  int       n_plane_ends = 0, n_batch_ends = 0, n_settings = 0;

  dir_row_t dir_rows[$] = '{
    '{'{pcrq_pkg::FUNC_LOAD,   6'd0,  32'sd1, 32'sd0, 5'd0, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd128}, 1'b1,
      '{-8'sd128, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd127}, 1'b1,
      '{8'sd127, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd0}, 1'b1,
      '{8'sd0, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd1}, 1'b1,
      '{-8'sd1, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_LOAD,   6'd63, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd31, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_LOAD,   6'd0,  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd31, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd127}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd128}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_LOAD,   6'd0,  32'sh8000_0000, 32'sh8000_0000, 5'd31, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd128}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd127}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    // halves round away from zero
    '{'{pcrq_pkg::FUNC_LOAD,   6'd0,  32'sd1, 32'sd0, 5'd1, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd3}, 1'b1,
      '{8'sd2, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd3}, 1'b1,
      '{-8'sd2, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd1}, 1'b1,
      '{8'sd1, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd1}, 1'b1,
      '{-8'sd1, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd2}, 1'b1,
      '{8'sd1, 1'b1, 1'b1}},
    // saturate at both ends
    '{'{pcrq_pkg::FUNC_LOAD,   6'd0,  32'sd1000, 32'sd0, 5'd0, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd127}, 1'b1,
      '{8'sd127, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd128}, 1'b1,
      '{-8'sd128, 1'b1, 1'b1}},
    '{'{pcrq_pkg::FUNC_LOAD,   6'd0,  -32'sd1, -32'sd5, 5'd2, 8'sd0}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, 8'sd5}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}},
    '{'{pcrq_pkg::FUNC_SAMPLE, 6'd0,  32'sd0, 32'sd0, 5'd0, -8'sd6}, 1'b0,
      '{8'sd0, 1'b0, 1'b0}}
  };

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endfunction

  // Requantise one sample for the current position, then advance the counters
  task automatic predict_act(input logic signed [7:0] x, output act_out_t o);
    int          plane, chans, imgs;
    logic [5:0]  ch;
    logic [4:0]  sh;
    logic [31:0] acc;
    logic [32:0] mag;
    logic [33:0] q;
    longint      r;
    bit          lp, lc, li;
    plane = (plane_reg == 0) ? 1 : int'(plane_reg);
    if (plane > 65536) plane = 65536;
    chans = (chans_reg == 0) ? 1 : int'(chans_reg);
    if (chans > 64) chans = 64;
    imgs = (batch_reg == 0) ? 1 : int'(batch_reg);
    ch = (chan_now >= chans) ? 6'(chans - 1) : chan_now;
    sh = shift_tab[ch];
    acc = {{24{x[7]}}, x} * mult_tab[ch] + bias_tab[ch];
    mag = acc[31] ? 33'h1_0000_0000 - {1'b0, acc} : {1'b0, acc};
    q = ({1'b0, mag} + ((sh == 5'd0) ? 34'd0 : (34'd1 << (sh - 5'd1)))) >> sh;
    r = acc[31] ? -longint'(q) : longint'(q);
    if (r < clamp_lo) r = clamp_lo;
    if (r > clamp_hi) r = clamp_hi;
    lp = pos_in_plane >= plane - 1;
    lc = chan_now >= chans - 1;
    li = image_now >= imgs - 1;
    o.act = r[7:0];
    o.eop = lp;
    o.eob = lp && lc && li;
    if (!lp) begin
      pos_in_plane = pos_in_plane + 16'd1;
    end else begin
      pos_in_plane = '0;
      if (!lc) begin
        chan_now = chan_now + 6'd1;
      end else begin
        chan_now = '0;
        image_now = li ? 16'd0 : image_now + 16'd1;
      end
    end
  endtask

  function automatic act_req_t random_request(input pcrq_pkg::func_e f,
                                              input logic [5:0] ch);
    act_req_t r;
    r.func = f;
    r.chan = ch;
    r.x = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      r.mult = $urandom;
      r.bias = $urandom;
      r.shift = 5'($urandom);
    end else begin
      // moderate scales so that most results land inside the int8 range
      r.mult = $signed(32'($urandom_range(0, 8192))) - 32'sd4096;
      r.bias = $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
      r.shift = 5'($urandom_range(6, 16));
    end
    return r;
  endfunction

  task automatic send_req(input act_req_t r, input logic typed, input act_out_t want);
    act_out_t o;
    while (!steady && $urandom_range(99) < 36) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    func_i          <= r.func;
    channel_index_i <= r.chan;
    multiplier_i    <= r.mult;
    bias_i          <= r.bias;
    shift_i         <= r.shift;
    sample_i        <= r.x;
    do @(posedge clk_i); while (full);
    if (r.func == pcrq_pkg::FUNC_LOAD) begin
      n_loads++;
      mult_tab[r.chan]  = r.mult;
      bias_tab[r.chan]  = r.bias;
      shift_tab[r.chan] = r.shift;
    end else begin
      n_samples++;
      predict_act(r.x, o);
      if (typed) o = want;
      pending_acts.push_back(o);
    end
  endtask

  task automatic write_reg(input pcrq_pkg::reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Hold requests until every result is back and the load tail has drained
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_acts.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi,
                           input logic [6:0] chans, input logic [16:0] plane,
                           input logic [15:0] batch, input int n_items, input bit hold);
    act_req_t r;
    settle();
    // junk above each register's width must be dropped
    write_reg(pcrq_pkg::REG_ACT_MIN, {24'($urandom), lo});
    write_reg(pcrq_pkg::REG_ACT_MAX, {24'($urandom), hi});
    write_reg(pcrq_pkg::REG_CHANNEL_COUNT, {25'($urandom), chans});
    write_reg(pcrq_pkg::REG_PLANE_SIZE, {15'($urandom), plane});
    write_reg(pcrq_pkg::REG_BATCH_COUNT, {16'($urandom), batch});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    clamp_lo  = lo;
    clamp_hi  = hi;
    chans_reg = chans;
    plane_reg = plane;
    batch_reg = batch;
    n_settings++;
    for (int i = 0; i < n_items; i++) begin
      if (hold && i == n_items / 2) begin
        push <= 1'b0;
        do @(posedge clk_i); while (pending_acts.size() != 0);
      end
      if ($urandom_range(11) == 0) r = random_request(pcrq_pkg::FUNC_LOAD, 6'($urandom));
      else r = random_request(pcrq_pkg::FUNC_SAMPLE, 6'($urandom));
      send_req(r, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    act_out_t got;
    act_out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got.act = result_o;
        got.eop = last_of_plane_o;
        got.eob = last_of_batch_o;
        if (pending_acts.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0d plane_end %0b batch_end %0b",
                                  got.act, got.eop, got.eob));
        end else begin
          want = pending_acts.pop_front();
          n_checked++;
          if (want.eop) n_plane_ends++;
          if (want.eob) n_batch_ends++;
          if (got !== want)
            note_mismatch($sformatf(
              "result %0d plane_end %0b batch_end %0b, expected %0d %0b %0b",
              got.act, got.eop, got.eob, want.act, want.eop, want.eob));
        end
      end
      pop <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no request, result or register write for %0d cycles",
               STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] a, b;
    logic [6:0] ch;
    logic [16:0] pl;
    logic [15:0] bt;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: every sample ends a plane and a batch
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    for (int c = 0; c < 64; c++) begin
      send_req(random_request(pcrq_pkg::FUNC_LOAD, 6'(c)), 1'b0, '0);
    end

    run_phase(8'h80, 8'h7F, 7'd3, 17'd4, 16'd2, 40, 1'b0);
    run_phase(8'hEC, 8'h14, 7'd64, 17'd2, 16'd1, 140, 1'b1);
    // crossed bounds, zero sizes
    run_phase(8'h32, 8'hCE, 7'd0, 17'd0, 16'd0, 25, 1'b0);
    // oversized counts, then shrink so the position runs past the plane end
    run_phase(8'h7F, 8'h7F, 7'd127, 17'h1FFFF, 16'hFFFF, 30, 1'b0);
    run_phase(8'h80, 8'h80, 7'd5, 17'd3, 16'hFFFF, 30, 1'b0);

    for (int p = 0; p < 9; p++) begin
      a = 8'($urandom);
      b = 8'($urandom);
      if ($urandom_range(3) != 0 && $signed(a) > $signed(b)) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
      case ($urandom_range(9))
        0:       ch = 7'd0;
        1:       ch = 7'($urandom_range(65, 127));
        2:       ch = 7'd64;
        default: ch = 7'($urandom_range(1, 8));
      endcase
      pl = ($urandom_range(7) == 0) ? 17'd0 : 17'($urandom_range(1, 6));
      bt = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      steady = (p == 4);
      run_phase(a, b, ch, pl, bt, steady ? 80 : 22, p == 6);
    end
    steady = 1'b0;
    settle();

    $display("%0d loads and %0d samples sent over %0d register settings",
             n_loads, n_samples, n_settings);
    $display("%0d results checked, %0d plane ends and %0d batch ends among them",
             n_checked, n_plane_ends, n_batch_ends);
    if (mismatches == 0 && pending_acts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_acts.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
